// ===== sv/soa_pkg.sv =====
// Shared types, constants and helper functions of the slab object allocator.
package soa_pkg;

    localparam int NUM_FRAMES      = 16;
    localparam int PAGE_BYTES      = 4096;
    localparam int HEADER_BYTES    = 64;
    localparam int NUM_CLASSES     = 7;
    localparam int MIN_OBJ_BYTES   = 32;
    localparam int MAX_OBJ_BYTES   = 2048;
    localparam int STACK_SLOTS     = 128;

    localparam int FRM_W  = 4;
    localparam int LINK_W = 5;
    localparam int CLS_W  = 3;
    localparam int OBJ_W  = 7;
    localparam int STK_W  = FRM_W + OBJ_W;

    localparam logic [LINK_W-1:0] NIL = 5'd31;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_DISABLED = 3'd1,
        STS_BAD_SIZE = 3'd2,
        STS_NO_FRAME = 3'd3,
        STS_BAD_ADDR = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_EVAL,
        S_STK,
        S_UNL,
        S_PSH1,
        S_PSH2,
        S_FIN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic        kind;
        logic [11:0] req_size;
        logic [15:0] obj_addr;
    } t_req;

    typedef struct packed {
        logic [15:0] result_addr;
        logic [2:0]  status;
        logic [4:0]  live_slabs;
        logic [31:0] alloc_total;
        logic [31:0] free_total;
    } t_rsp;

    typedef struct packed {
        logic [CLS_W-1:0] cls;
        logic [OBJ_W-1:0] cnt;
        logic [OBJ_W-1:0] fresh;
        logic [OBJ_W-1:0] depth;
        logic             on_full;
    } t_rec;

    // smallest class whose object fits; all ones when none does
    function automatic logic [CLS_W-1:0] size_class(input logic [11:0] size);
        logic [CLS_W-1:0] c;
        c = '1;
        for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
            if (13'(size) <= (13'(MIN_OBJ_BYTES) << i)) begin
                c = CLS_W'(i);
            end
        end
        return c;
    endfunction

    function automatic logic [OBJ_W-1:0] objs_in_class(input logic [CLS_W-1:0] c);
        logic [11:0] t;
        t = 12'(PAGE_BYTES - HEADER_BYTES) >> (4'd5 + 4'(c));
        return t[OBJ_W-1:0];
    endfunction

endpackage

// ===== sv/slab_object_allocator.sv =====
// Slab object allocator top level: request sequencer over frame record memories.
// Sequence: a request rejected on entry goes straight to the result word; others pass
// through record read, update, optional freed-stack read and list relinks first.
// One request at a time: o_stall holds off the next until the result is taken, through the
// read-modify-write sequence on the frame record, link and freed-object memories.
// Reset: synchronous, clears live bits, list heads, counters and enable; memories are not cleared.
module slab_object_allocator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  soa_pkg::t_req i_req,
    output logic          o_valid,
    input  logic          i_stall,
    output soa_pkg::t_rsp o_rsp,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic          i_cfg_data
);
    import soa_pkg::*;

    t_state r_state, n_state;

    logic                r_en;
    logic                r_kind;
    logic [CLS_W-1:0]    r_cls;
    logic [FRM_W-1:0]    r_frm;
    logic [11:0]         r_off;
    logic [2:0]          r_status;
    logic                r_claim;
    logic [OBJ_W-1:0]    r_idx;
    logic [LINK_W-1:0]   r_p, r_n, r_h;
    logic                r_unl, r_unl_full, r_psh, r_psh_full;
    logic [NUM_FRAMES-1:0] r_live;
    logic [LINK_W-1:0]   r_part [NUM_CLASSES];
    logic [LINK_W-1:0]   r_full [NUM_CLASSES];
    logic [4:0]          r_slabs;
    logic [31:0]         r_acnt, r_fcnt;
    logic                r_ovalid;
    t_rsp                r_out;

    // memory ports
    t_rec              rd_rec, wr_rec;
    logic              rec_we;
    logic [LINK_W-1:0] rd_next, rd_prev;
    logic              nx_we, pv_we;
    logic [FRM_W-1:0]  nx_waddr, pv_waddr;
    logic [LINK_W-1:0] nx_wdata, pv_wdata;
    logic [OBJ_W-1:0]  stk_rdata, stk_wdata;
    logic              stk_we;
    logic [STK_W-1:0]  stk_waddr, stk_raddr;

    // request decode
    logic              acc;
    logic [CLS_W-1:0]  q_cls;
    logic [LINK_W-1:0] q_pf;
    logic [FRM_W-1:0]  q_free_f;
    logic              q_any_free;
    logic [2:0]        q_status;

    // evaluation
    logic              e_ok;
    logic [OBJ_W-1:0]  e_idx;
    logic              e_stk;
    logic              e_unl, e_unl_full, e_psh, e_psh_full;
    logic              e_live_set, e_live_clr;
    logic [11:0]       f_off2, f_mask, f_idx12;
    logic [OBJ_W-1:0]  f_objs, f_cnt, a_cnt, c_cnt;

    logic [LINK_W-1:0] cur_head;
    logic [15:0]       res_addr;

    assign o_stall     = (r_state != S_IDLE);
    assign acc         = i_valid && !o_stall;
    assign o_valid     = r_ovalid;
    assign o_rsp       = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        q_cls      = size_class(i_req.req_size);
        q_pf       = (q_cls < CLS_W'(NUM_CLASSES)) ? r_part[q_cls] : NIL;
        q_free_f   = '0;
        q_any_free = 1'b0;
        for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
            if (!r_live[i]) begin
                q_free_f   = FRM_W'(i);
                q_any_free = 1'b1;
            end
        end
        if (!r_en) begin
            q_status = STS_DISABLED;
        end else if (i_req.kind) begin
            q_status = STS_OK;
        end else if (i_req.req_size == 12'd0 || i_req.req_size > 12'(MAX_OBJ_BYTES)
                     || q_cls >= CLS_W'(NUM_CLASSES)) begin
            q_status = STS_BAD_SIZE;
        end else if (q_pf >= LINK_W'(NUM_FRAMES) && !q_any_free) begin
            q_status = STS_NO_FRAME;
        end else begin
            q_status = STS_OK;
        end
    end

    always_comb begin
        f_off2  = r_off - 12'(HEADER_BYTES);
        f_mask  = (12'd32 << rd_rec.cls) - 12'd1;
        f_idx12 = f_off2 >> (4'd5 + 4'(rd_rec.cls));
        f_objs  = objs_in_class(rd_rec.cls);
        f_cnt   = rd_rec.cnt + 7'd1;
        a_cnt   = rd_rec.cnt - 7'd1;
        c_cnt   = objs_in_class(r_cls) - 7'd1;

        e_ok       = 1'b1;
        e_idx      = '0;
        e_stk      = 1'b0;
        e_unl      = 1'b0;
        e_unl_full = 1'b0;
        e_psh      = 1'b0;
        e_psh_full = 1'b0;
        e_live_set = 1'b0;
        e_live_clr = 1'b0;
        wr_rec     = rd_rec;

        if (!r_kind && r_claim) begin
            wr_rec.cls     = r_cls;
            wr_rec.cnt     = c_cnt;
            wr_rec.fresh   = 7'd1;
            wr_rec.depth   = '0;
            wr_rec.on_full = (c_cnt == '0);
            e_live_set     = 1'b1;
            e_psh          = 1'b1;
            e_psh_full     = (c_cnt == '0);
        end else if (!r_kind) begin
            wr_rec.cnt = a_cnt;
            if (rd_rec.depth != '0) begin
                wr_rec.depth = rd_rec.depth - 7'd1;
                e_stk        = 1'b1;
            end else begin
                e_idx        = rd_rec.fresh;
                wr_rec.fresh = rd_rec.fresh + 7'd1;
            end
            if (a_cnt == '0) begin
                wr_rec.on_full = 1'b1;
                e_unl          = 1'b1;
                e_psh          = 1'b1;
                e_psh_full     = 1'b1;
            end
        end else begin
            e_ok = r_live[r_frm] && r_off >= 12'(HEADER_BYTES)
                   && rd_rec.cls < CLS_W'(NUM_CLASSES)
                   && (f_off2 & f_mask) == '0 && f_idx12 < 12'(f_objs);
            e_idx        = f_idx12[OBJ_W-1:0];
            wr_rec.depth = rd_rec.depth + 7'd1;
            wr_rec.cnt   = f_cnt;
            if (f_cnt == f_objs) begin
                e_unl      = 1'b1;
                e_unl_full = rd_rec.on_full;
                e_live_clr = 1'b1;
            end else if (f_cnt == 7'd1 && rd_rec.on_full) begin
                wr_rec.on_full = 1'b0;
                e_unl          = 1'b1;
                e_unl_full     = 1'b1;
                e_psh          = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (acc) n_state = (q_status != STS_OK) ? S_FIN : S_RD;
            S_RD:   n_state = S_EVAL;
            S_EVAL: begin
                if (!e_ok) n_state = S_FIN;
                else if (e_stk) n_state = S_STK;
                else if (e_unl) n_state = S_UNL;
                else if (e_psh) n_state = S_PSH1;
                else n_state = S_FIN;
            end
            S_STK:  n_state = r_unl ? S_UNL : S_FIN;
            S_UNL:  n_state = r_psh ? S_PSH1 : S_FIN;
            S_PSH1: n_state = S_PSH2;
            S_PSH2: n_state = S_FIN;
            S_FIN:  n_state = S_OUT;
            S_OUT:  if (!i_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        cur_head  = r_psh_full ? r_full[r_cls] : r_part[r_cls];
        rec_we    = (r_state == S_EVAL) && e_ok;
        stk_we    = (r_state == S_EVAL) && r_kind && e_ok;
        stk_waddr = {r_frm, rd_rec.depth};
        stk_wdata = e_idx;
        stk_raddr = {r_frm, rd_rec.depth - 7'd1};
        nx_we     = 1'b0;
        nx_waddr  = r_frm;
        nx_wdata  = cur_head;
        pv_we     = 1'b0;
        pv_waddr  = r_frm;
        pv_wdata  = NIL;
        unique case (r_state)
            S_UNL: begin
                nx_we    = (r_p < LINK_W'(NUM_FRAMES));
                nx_waddr = r_p[FRM_W-1:0];
                nx_wdata = r_n;
                pv_we    = (r_n < LINK_W'(NUM_FRAMES));
                pv_waddr = r_n[FRM_W-1:0];
                pv_wdata = r_p;
            end
            S_PSH1: begin
                nx_we = 1'b1;
                pv_we = 1'b1;
            end
            S_PSH2: begin
                pv_we    = (r_h < LINK_W'(NUM_FRAMES));
                pv_waddr = r_h[FRM_W-1:0];
                pv_wdata = LINK_W'(r_frm);
            end
            default: begin
            end
        endcase
    end

    soa_ram #(.W($bits(t_rec)), .D(NUM_FRAMES)) u_rec (
        .i_clk(i_clk), .i_we(rec_we), .i_waddr(r_frm), .i_wdata(wr_rec),
        .i_raddr(r_frm), .o_rdata(rd_rec)
    );

    soa_ram #(.W(LINK_W), .D(NUM_FRAMES)) u_next (
        .i_clk(i_clk), .i_we(nx_we), .i_waddr(nx_waddr), .i_wdata(nx_wdata),
        .i_raddr(r_frm), .o_rdata(rd_next)
    );

    soa_ram #(.W(LINK_W), .D(NUM_FRAMES)) u_prev (
        .i_clk(i_clk), .i_we(pv_we), .i_waddr(pv_waddr), .i_wdata(pv_wdata),
        .i_raddr(r_frm), .o_rdata(rd_prev)
    );

    soa_ram #(.W(OBJ_W), .D(NUM_FRAMES * STACK_SLOTS)) u_stk (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );

    assign res_addr = 16'({r_frm, 12'd0}) + 16'(HEADER_BYTES)
                      + 16'(18'(r_idx) << (4'd5 + 4'(r_cls)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_en     <= 1'b0;
            r_live   <= '0;
            r_slabs  <= '0;
            r_acnt   <= '0;
            r_fcnt   <= '0;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++) begin
                r_part[i] <= NIL;
                r_full[i] <= NIL;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_en <= i_cfg_data;
            unique case (r_state)
                S_EVAL: begin
                    if (e_ok) begin
                        if (r_kind) begin
                            r_fcnt <= r_fcnt + 32'd1;
                        end else begin
                            r_acnt <= r_acnt + 32'd1;
                        end
                    end
                    if (e_ok && e_live_set) begin
                        r_live[r_frm] <= 1'b1;
                        r_slabs       <= r_slabs + 5'd1;
                    end
                    if (e_ok && e_live_clr) begin
                        r_live[r_frm] <= 1'b0;
                        r_slabs       <= r_slabs - 5'd1;
                    end
                end
                S_UNL: begin
                    if (r_p >= LINK_W'(NUM_FRAMES)) begin
                        if (r_unl_full) r_full[r_cls] <= r_n;
                        else r_part[r_cls] <= r_n;
                    end
                end
                S_PSH1: begin
                    if (r_psh_full) r_full[r_cls] <= LINK_W'(r_frm);
                    else r_part[r_cls] <= LINK_W'(r_frm);
                end
                S_FIN:  r_ovalid <= 1'b1;
                S_OUT:  if (!i_stall) r_ovalid <= 1'b0;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_kind   <= i_req.kind;
                r_cls    <= q_cls;
                r_off    <= i_req.obj_addr[11:0];
                r_status <= q_status;
                r_claim  <= (q_pf >= LINK_W'(NUM_FRAMES));
                if (i_req.kind) r_frm <= i_req.obj_addr[15:12];
                else if (q_pf < LINK_W'(NUM_FRAMES)) r_frm <= q_pf[FRM_W-1:0];
                else r_frm <= q_free_f;
            end
            S_EVAL: begin
                if (r_kind && e_ok) r_cls <= rd_rec.cls;
                if (!e_ok) r_status <= STS_BAD_ADDR;
                r_idx      <= e_idx;
                r_p        <= rd_prev;
                r_n        <= rd_next;
                r_unl      <= e_unl;
                r_unl_full <= e_unl_full;
                r_psh      <= e_psh;
                r_psh_full <= e_psh_full;
            end
            S_STK:  r_idx <= stk_rdata;
            S_PSH1: r_h <= cur_head;
            S_FIN: begin
                r_out.result_addr <= (r_status == STS_OK && !r_kind) ? res_addr : 16'd0;
                r_out.status      <= r_status;
                r_out.live_slabs  <= r_slabs;
                r_out.alloc_total <= r_acnt;
                r_out.free_total  <= r_fcnt;
            end
            default: begin
            end
        endcase
    end

    a_busy_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> o_stall) else $error("result pending while idle");

    a_slab_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_live) == 32'(r_slabs)) else $error("slab count off live bits");

    a_stk_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_STK |-> $past(r_state) == S_EVAL) else $error("stack read out of order");

endmodule

// ===== sv/soa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module soa_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
